@@ rtl/enmc_pkg.sv @@
package enmc_pkg;

  localparam int COORD_W       = 32;
  localparam int TICK_W        = 32;
  localparam int TOL_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [TICK_W-1:0] EXPIRY_RESET = TICK_W'(60000);
  localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(10);
  localparam logic              DEDUP_RESET  = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP  = CFG_IDX_W'(2);

  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic [TICK_W-1:0]         stamp;
  } entry_t;

  typedef struct packed {
    logic near;
    logic expired;
  } eval_t;

endpackage

@@ rtl/enmc_if.sv @@
interface enmc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [enmc_pkg::COORD_W-1:0]  start_x;
  logic signed [enmc_pkg::COORD_W-1:0]  start_y;
  logic signed [enmc_pkg::COORD_W-1:0]  target_x;
  logic signed [enmc_pkg::COORD_W-1:0]  target_y;
  logic [enmc_pkg::TICK_W-1:0]          now_tick;

  modport source (output valid, req_type, start_x, start_y, target_x, target_y, now_tick,
                  input ready);
  modport sink (input valid, req_type, start_x, start_y, target_x, target_y, now_tick,
                output ready);
endinterface

interface enmc_rsp_if;
  logic valid;
  logic ready;
  logic unreachable;
  logic dropped_oldest;

  modport source (output valid, unreachable, dropped_oldest, input ready);
  modport sink (input valid, unreachable, dropped_oldest, output ready);
endinterface

interface enmc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [enmc_pkg::CFG_IDX_W-1:0]     index;
  logic [enmc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/expiring_near_match_miss_cache.sv @@
// Miss cache of failed start/target pairs with expiry and near matching.
// Channels: req (sink) takes one request per transfer, req_type 0 queries a
// pair, 1 reports a failed pair; rsp (source) returns one result per request
// (unreachable, dropped_oldest); cfg (sink) writes expiry_ticks (index 0),
// near_tolerance (1) and dedup_enable (2), other indexes are ignored. cfg is
// always ready; it must be written only while no request is in flight, and
// the block itself does not enforce this. One request is worked at a time.
// The table sits in one memory with a registered read port; the walk reads
// one entry per cycle and writes kept entries back compacted. A query walks
// the stored entries and stops early on a hit with nothing purged. A report
// without dedup appends directly, or, when the table is full, first walks to
// drop the oldest entry while every other entry moves down one slot. A report
// with dedup walks once, and if it appends to a full table, walks a second
// time. The next request can be taken in the same cycle that the result goes
// valid. req is ready whenever no request is being worked, even while a
// result still waits on rsp; a stalled rsp only holds the finished request
// in its last state. Reset empties the table (count to zero, no memory
// sweep) and loads the register defaults.
module expiring_near_match_miss_cache #(
  parameter int TABLE_DEPTH = enmc_pkg::DEFAULT_DEPTH
) (
  input logic clk,
  input logic rst,
  enmc_req_if.sink   req,
  enmc_rsp_if.source rsp,
  enmc_cfg_if.sink   cfg
);
  import enmc_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  localparam logic [1:0] M_QUERY = 2'd0;
  localparam logic [1:0] M_DEDUP = 2'd1;
  localparam logic [1:0] M_DROP  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        mode;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  w_ptr;
  logic [CNT_W-1:0]  count;
  logic              dv;
  logic              hit;
  logic              any_drop;
  logic              dropped;
  entry_t            probe;

  logic [TICK_W-1:0] expiry;
  logic [TOL_W-1:0]  tol;
  logic              dedup;

  logic              rsp_valid;
  logic              rsp_unreach;
  logic              rsp_drop;
  logic              fin_fire;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  entry_t            wr_data;
  entry_t            walk_data;
  logic [IDX_W-1:0]  wr_addr;
  logic              we;
  logic              rd_en;

  eval_t             ev;
  logic              eval_now;
  logic              drop_e;
  logic              near_e;
  logic              stop_e;
  logic              walk_done;

  enmc_match u_match (
    .entry     (rd_data),
    .probe     (probe),
    .tolerance (tol),
    .expiry    (expiry),
    .result    (ev)
  );

  assign req.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.unreachable    = rsp_unreach;
  assign rsp.dropped_oldest = rsp_drop;

  assign fin_fire = (state == S_FIN) && (!rsp_valid || rsp.ready);

  always_comb begin
    rd_en     = (state == S_WALK) && (rd_ptr < count);
    walk_done = (state == S_WALK) && !dv && (rd_ptr == count);
    eval_now  = (state == S_WALK) && dv;
    drop_e    = ((mode == M_QUERY) && !hit && ev.expired) ||
                ((mode == M_DROP) && !any_drop);
    near_e    = eval_now && !drop_e && !hit && (mode != M_DROP) && ev.near;
    stop_e    = near_e && ((mode == M_DEDUP) || !any_drop);

    walk_data = rd_data;
    if ((mode == M_DEDUP) && near_e) begin
      walk_data.stamp = probe.stamp;
    end

    if (state == S_APPEND) begin
      we      = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_data = probe;
    end else begin
      we      = eval_now && !drop_e;
      wr_addr = w_ptr[IDX_W-1:0];
      wr_data = walk_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= EXPIRY_RESET;
      tol    <= TOL_RESET;
      dedup  <= DEDUP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_EXPIRY: expiry <= cfg.data[TICK_W-1:0];
        CFG_TOL:    tol    <= cfg.data[TOL_W-1:0];
        CFG_DEDUP:  dedup  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_QUERY;
      rd_ptr    <= '0;
      w_ptr     <= '0;
      count     <= '0;
      dv        <= 1'b0;
      hit       <= 1'b0;
      any_drop  <= 1'b0;
      dropped   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (fin_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            probe.sx    <= req.start_x;
            probe.sy    <= req.start_y;
            probe.tx    <= req.target_x;
            probe.ty    <= req.target_y;
            probe.stamp <= req.now_tick;
            rd_ptr      <= '0;
            w_ptr       <= '0;
            dv          <= 1'b0;
            hit         <= 1'b0;
            any_drop    <= 1'b0;
            dropped     <= 1'b0;
            if (req.req_type == REQ_QUERY) begin
              mode  <= M_QUERY;
              state <= S_WALK;
            end else if (dedup) begin
              mode  <= M_DEDUP;
              state <= S_WALK;
            end else if (count >= DEPTH_C) begin
              mode  <= M_DROP;
              state <= S_WALK;
            end else begin
              state <= S_APPEND;
            end
          end
        end
        S_WALK: begin
          if (rd_en) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          dv <= rd_en && !stop_e;
          if (eval_now) begin
            if (!drop_e) begin
              w_ptr <= w_ptr + CNT_W'(1);
            end else begin
              any_drop <= 1'b1;
            end
            if (near_e && (mode == M_QUERY)) begin
              hit <= 1'b1;
            end
          end
          if (stop_e) begin
            state <= S_FIN;
          end else if (walk_done) begin
            count <= w_ptr;
            if (mode == M_QUERY) begin
              state <= S_FIN;
            end else if (mode == M_DROP) begin
              dropped <= 1'b1;
              state   <= S_APPEND;
            end else if (count >= DEPTH_C) begin
              mode     <= M_DROP;
              rd_ptr   <= '0;
              w_ptr    <= '0;
              any_drop <= 1'b0;
            end else begin
              state <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          count <= count + CNT_W'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            rsp_unreach <= hit;
            rsp_drop    <= dropped;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (w_ptr <= rd_ptr))
    else $error("write pointer passed read pointer");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not grow the table");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && mode == M_DROP && walk_done) |-> (w_ptr == DEPTH_C - CNT_W'(1)))
    else $error("oldest drop did not leave one free slot");

endmodule

@@ rtl/enmc_match.sv @@
module enmc_match (
  input  enmc_pkg::entry_t             entry,
  input  enmc_pkg::entry_t             probe,
  input  logic [enmc_pkg::TOL_W-1:0]   tolerance,
  input  logic [enmc_pkg::TICK_W-1:0]  expiry,
  output enmc_pkg::eval_t              result
);
  import enmc_pkg::*;

  localparam int DIFF_W = COORD_W + 1;

  logic [TICK_W-1:0] age;

  function automatic logic axis_near(input logic signed [COORD_W-1:0] a,
                                     input logic signed [COORD_W-1:0] b,
                                     input logic [TOL_W-1:0] tol);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] lim;
    d   = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    lim = $signed({{(DIFF_W - TOL_W){1'b0}}, tol});
    return (d <= lim) && (d >= -lim);
  endfunction

  assign age = probe.stamp - entry.stamp;

  assign result.expired = age > expiry;
  assign result.near    = axis_near(probe.sx, entry.sx, tolerance) &&
                          axis_near(probe.sy, entry.sy, tolerance) &&
                          axis_near(probe.tx, entry.tx, tolerance) &&
                          axis_near(probe.ty, entry.ty, tolerance);

endmodule
